/* rtl/itfc_pkg.sv */
// Shared types and constants for the IMU text frame calibrator.
`timescale 1ns / 1ps

package itfc_pkg;

    localparam int MAX_FRAME_BYTES     = 256;
    localparam int SCALE_FRACTION_BITS = 14;

    localparam int LaneW        = 20;
    localparam int NumChan      = 9;
    localparam int NumLane      = 3;
    localparam int OutW         = 41;
    localparam int ByteCntW     = $clog2(MAX_FRAME_BYTES);
    localparam int TokensWanted = 10;
    localparam int CfgW         = LaneW * NumLane;

    localparam logic [LaneW-1:0] MagLimit = LaneW'(524288);
    localparam logic [LaneW-1:0] ScaleOne = LaneW'(1 << SCALE_FRACTION_BITS);

    localparam logic [7:0] CharA     = 8'h41;
    localparam logic [7:0] CharZ     = 8'h5A;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] Char0     = 8'h30;
    localparam logic [7:0] Char9     = 8'h39;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0D;

    typedef enum logic [2:0] {
        CfgMagBias   = 3'd0,
        CfgAccelBias = 3'd1,
        CfgGyroBias  = 3'd2,
        CfgMagScale  = 3'd3,
        CfgAccelScale = 3'd4,
        CfgGyroScale = 3'd5
    } t_cfg_idx;

    typedef logic [LaneW-1:0]              t_lane;
    typedef t_lane [NumChan-1:0]           t_chans;
    typedef t_lane [NumLane-1:0]           t_lanes3;
    typedef logic signed [OutW-1:0]        t_res;
    typedef t_res [NumChan-1:0]            t_results;

    typedef struct packed {
        logic   status;
        t_chans chan;
    } t_frame;

endpackage

/* rtl/itfc_front.sv */
// Front end: byte classification, tokenizer and frame framing.
`timescale 1ns / 1ps

module itfc_front
    import itfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_frame     o_frame
);

    logic                r_in_frame;
    logic [ByteCntW-1:0] r_fbc;
    logic [3:0]          r_tcnt;
    logic                r_in_tok;
    logic                r_neg;
    logic                r_stop;
    t_lane               r_acc;
    t_chans              r_chan;

    logic                accept;
    logic                is_ws;
    logic                is_digit;
    logic                is_sign;
    logic                is_z;
    logic [ByteCntW:0]   fbc_sum;
    logic                close;
    logic                n_in_tok;
    logic                n_neg;
    logic                n_stop;
    t_lane               n_acc;
    logic [3:0]          n_tcnt;
    logic                start_tok;
    logic                base_stop;
    t_lane               base_acc;
    logic [23:0]         acc_mul;
    logic                fin_en;
    t_lane               fin_val;
    logic [3:0]          fin_idx;
    t_chans              n_chan;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;

    assign is_ws    = (i_byte == CharSpace) || (i_byte == CharNul) ||
                      ((i_byte >= CharTab) && (i_byte <= CharCr));
    assign is_digit = (i_byte >= Char0) && (i_byte <= Char9);
    assign is_sign  = (i_byte == CharPlus) || (i_byte == CharMinus);
    assign is_z     = (i_byte == CharZ);
    assign fbc_sum  = {1'b0, r_fbc} + (ByteCntW+1)'(1);

    always_comb begin
        n_in_tok  = r_in_tok;
        n_neg     = r_neg;
        n_stop    = r_stop;
        n_acc     = r_acc;
        n_tcnt    = r_tcnt;
        start_tok = !r_in_tok;
        base_stop = start_tok ? 1'b0 : r_stop;
        base_acc  = start_tok ? '0 : r_acc;
        acc_mul   = {4'b0, base_acc} * 24'd10 + {16'b0, i_byte - Char0};
        if (!is_z) begin
            if (is_ws) begin
                n_in_tok = 1'b0;
            end else begin
                n_in_tok = 1'b1;
                if (start_tok) begin
                    n_neg  = 1'b0;
                    n_tcnt = (r_tcnt == 4'hF) ? r_tcnt : r_tcnt + 4'd1;
                end
                n_stop = base_stop;
                n_acc  = base_acc;
                if (start_tok && is_sign) begin
                    n_neg = (i_byte == CharMinus);
                end else if (!base_stop && is_digit) begin
                    n_acc = (acc_mul > {4'b0, MagLimit}) ? MagLimit : acc_mul[LaneW-1:0];
                end else begin
                    n_stop = 1'b1;
                end
            end
        end
    end

    assign close   = is_z || (fbc_sum >= (ByteCntW+1)'(MAX_FRAME_BYTES - 1));
    assign fin_en  = (is_ws && r_in_tok) || (close && n_in_tok);
    assign fin_val = n_neg ? (LaneW'(0) - n_acc)
                           : ((n_acc > MagLimit - LaneW'(1)) ? MagLimit - LaneW'(1) : n_acc);
    assign fin_idx = n_tcnt - 4'd2;

    always_comb begin
        n_chan = r_chan;
        if (fin_en && (n_tcnt >= 4'd2) && (n_tcnt <= 4'(TokensWanted))) begin
            n_chan[fin_idx] = fin_val;
        end
    end

    assign o_push         = accept && r_in_frame && close;
    assign o_frame.status = (n_tcnt != 4'(TokensWanted));
    assign o_frame.chan   = n_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fbc      <= '0;
            r_tcnt     <= '0;
            r_in_tok   <= 1'b0;
            r_neg      <= 1'b0;
            r_stop     <= 1'b0;
            r_acc      <= '0;
        end else if (accept) begin
            if (!r_in_frame) begin
                if (i_byte == CharA) begin
                    r_in_frame <= 1'b1;
                end
                r_fbc    <= '0;
                r_tcnt   <= '0;
                r_in_tok <= 1'b0;
                r_neg    <= 1'b0;
                r_stop   <= 1'b0;
                r_acc    <= '0;
            end else if (close) begin
                r_in_frame <= 1'b0;
                r_fbc      <= '0;
                r_tcnt     <= '0;
                r_in_tok   <= 1'b0;
                r_neg      <= 1'b0;
                r_stop     <= 1'b0;
                r_acc      <= '0;
            end else begin
                r_fbc    <= fbc_sum[ByteCntW-1:0];
                r_tcnt   <= n_tcnt;
                r_in_tok <= n_in_tok;
                r_neg    <= n_neg;
                r_stop   <= n_stop;
                r_acc    <= n_acc;
            end
        end
    end

    // channel store: no reset, every read follows a write in the same frame
    always_ff @(posedge i_clk) begin
        if (accept && r_in_frame) begin
            r_chan <= n_chan;
        end
    end

endmodule

/* rtl/itfc_queue.sv */
// Two-entry queue of closed frames between front and back.
`timescale 1ns / 1ps

module itfc_queue
    import itfc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_frame
);

    t_frame     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_frame = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

endmodule

/* rtl/itfc_back.sv */
// Back end: calibration registers, shared multiplier and result register.
`timescale 1ns / 1ps

module itfc_back
    import itfc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic            i_q_valid,
    input  t_frame          i_q_frame,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_status,
    output t_results        o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state             r_state;
    t_lanes3            r_bias  [NumLane];
    t_lanes3            r_scale [NumLane];
    t_chans             r_chan;
    logic [3:0]         r_k;
    logic [1:0]         r_grp;
    logic [1:0]         r_lane;
    logic               r_pv;
    logic [3:0]         r_pk;
    logic signed [LaneW:0]   r_d;
    logic signed [LaneW-1:0] r_s;
    logic               r_status;
    t_results           r_res;

    logic               issue;
    t_lane              cur_val;
    t_lane              cur_bias;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = (r_state == S_HOLD);
    assign o_status = r_status;
    assign o_res    = r_res;

    assign issue    = (r_state == S_RUN) && (r_k < 4'(NumChan));
    assign cur_val  = r_chan[r_k];
    assign cur_bias = r_bias[r_grp][r_lane];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_grp   <= '0;
            r_lane  <= '0;
            r_pv    <= 1'b0;
            for (int i = 0; i < NumLane; i++) begin
                r_bias[i]  <= '0;
                r_scale[i] <= {NumLane{ScaleOne}};
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMagBias:    r_bias[0]  <= i_cfg_data;
                    CfgAccelBias:  r_bias[1]  <= i_cfg_data;
                    CfgGyroBias:   r_bias[2]  <= i_cfg_data;
                    CfgMagScale:   r_scale[0] <= i_cfg_data;
                    CfgAccelScale: r_scale[1] <= i_cfg_data;
                    CfgGyroScale:  r_scale[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pv <= issue;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_k    <= '0;
                        r_grp  <= '0;
                        r_lane <= '0;
                        r_state <= i_q_frame.status ? S_HOLD : S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        r_k <= r_k + 4'd1;
                        if (r_lane == 2'(NumLane - 1)) begin
                            r_lane <= '0;
                            r_grp  <= r_grp + 2'd1;
                        end else begin
                            r_lane <= r_lane + 2'd1;
                        end
                    end
                    if (r_pv && (r_pk == 4'(NumChan - 1))) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_chan   <= i_q_frame.chan;
            r_status <= i_q_frame.status;
            r_res    <= '0;
        end else if (r_pv) begin
            r_res[r_pk] <= r_d * r_s;
        end
        if (issue) begin
            r_d  <= $signed({cur_val[LaneW-1], cur_val}) -
                    $signed({cur_bias[LaneW-1], cur_bias});
            r_s  <= $signed(r_scale[r_grp][r_lane]);
            r_pk <= r_k;
        end
    end

endmodule

/* rtl/imu_text_frame_calibrator.sv */
// Top level of the IMU text frame calibrator.
`timescale 1ns / 1ps

// Takes one ASCII byte per item and can accept a byte every clock. Bytes before
// 'A' are dropped; a frame closes at 'Z' or after 255 bytes and then gives one
// result. A good frame (ten tokens) is calibrated by one shared 21x20-bit
// multiplier, one channel per cycle. With the back end free, a closed frame
// is queued and popped, and its result is offered once the last product is
// registered; an error result skips the multiplier. Closed frames wait in a
// two-entry queue, so input stalls only while two frames wait behind the one
// being calibrated or held for output. Configuration is written through a
// plain write port, one 60-bit register (three packed 20-bit lanes) per index.

module imu_text_frame_calibrator
    import itfc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // rx_byte
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // mag_x, mag_y, mag_z, accel_x, accel_y, accel_z, rate_p, rate_q, rate_r
    output logic [375:0]    m_axis_tdata,
    output logic            m_axis_tuser,   // frame_status
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data
);

    logic     q_full;
    logic     q_push;
    t_frame   q_in;
    logic     q_pop;
    logic     q_valid;
    t_frame   q_out;
    t_results res;

    itfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_frame  (q_in)
    );

    itfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_frame (q_out)
    );

    itfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_frame  (q_out),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (m_axis_tuser),
        .o_res      (res)
    );

    assign m_axis_tdata = {7'b0, res};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero data");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("frame pushed into a full queue");

    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated after handshake");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && !m_axis_tvalid))
        else $error("queue popped while empty or result held");

endmodule

/* tb/frame_calib_checker.sv */
// Checker for the IMU text frame calibrator: predicts every frame result and compares it.
`timescale 1ns / 1ps

module frame_calib_checker
    import itfc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // rx_byte
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // mag_x, mag_y, mag_z, accel_x, accel_y, accel_z, rate_p, rate_q, rate_r
    input  logic [375:0]    m_axis_tdata,
    input  logic            m_axis_tuser,   // frame_status
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending,
    output int              o_results
);

    localparam logic [7:0] CharLf = 8'h0A;
    localparam logic [7:0] CharVt = 8'h0B;
    localparam logic [7:0] CharFf = 8'h0C;
    localparam int MaxTokens = 15;

    typedef struct packed {
        logic     status;
        t_results res;
    } t_frame_out;

    t_frame_out                calibrated_q[$];
    bit                        in_frame;
    logic [ByteCntW-1:0]       frame_bytes;
    logic [3:0]                tok_cnt;
    bit                        in_tok;
    bit                        tok_neg;
    bit                        tok_stop;
    int unsigned               tok_mag;
    t_chans                    chan_val;
    t_lanes3                   bias [3];
    t_lanes3                   gain [3];
    int                        errors = 0;
    int                        results = 0;

    function automatic bit is_sep(input logic [7:0] c);
        return c == CharSpace || c == CharTab || c == CharLf || c == CharVt ||
               c == CharFf || c == CharCr || c == CharNul;
    endfunction

    function automatic string chan_name(input int i);
        case (i)
            0: return "mag_x";
            1: return "mag_y";
            2: return "mag_z";
            3: return "accel_x";
            4: return "accel_y";
            5: return "accel_z";
            6: return "rate_p";
            7: return "rate_q";
            default: return "rate_r";
        endcase
    endfunction

    // (value - bias) * gain, all lanes signed
    function automatic t_res calibrate(input t_lane v, input t_lane b, input t_lane g);
        longint d;
        longint p;
        d = longint'($signed(v)) - longint'($signed(b));
        p = d * longint'($signed(g));
        return p[OutW-1:0];
    endfunction

    task automatic clear_token_state;
        frame_bytes = '0;
        tok_cnt     = '0;
        in_tok      = 0;
        tok_neg     = 0;
        tok_stop    = 0;
        tok_mag     = 0;
    endtask

    task automatic end_token;
        t_lane v;
        if (in_tok) begin
            if (tok_neg)
                v = t_lane'(32'd0 - tok_mag);
            else
                v = (tok_mag > MagLimit - 1) ? MagLimit - 1 : t_lane'(tok_mag);
            if (tok_cnt >= 2 && tok_cnt <= TokensWanted)
                chan_val[tok_cnt - 2] = v;
        end
        in_tok = 0;
    endtask

    task automatic close_frame;
        t_frame_out fo;
        int i;
        end_token();
        fo = '0;
        if (tok_cnt == TokensWanted) begin
            for (i = 0; i < NumChan; i++)
                fo.res[i] = calibrate(chan_val[i], bias[i / 3][i % 3], gain[i / 3][i % 3]);
        end else begin
            fo.status = 1'b1;
        end
        calibrated_q.push_back(fo);
        in_frame = 0;
        clear_token_state();
    endtask

    task automatic take_byte(input logic [7:0] c);
        bit first;
        int unsigned n;
        if (!in_frame) begin
            if (c == CharA) begin
                in_frame = 1;
                clear_token_state();
            end
        end else if (c == CharZ) begin
            close_frame();
        end else begin
            if (is_sep(c)) begin
                end_token();
            end else begin
                first = 0;
                if (!in_tok) begin
                    in_tok   = 1;
                    tok_neg  = 0;
                    tok_stop = 0;
                    tok_mag  = 0;
                    if (tok_cnt < MaxTokens)
                        tok_cnt++;
                    first = 1;
                end
                if (first && (c == CharMinus || c == CharPlus)) begin
                    tok_neg = (c == CharMinus);
                end else if (!tok_stop && c >= Char0 && c <= Char9) begin
                    n = tok_mag * 10 + (c - Char0);
                    tok_mag = (n > MagLimit) ? MagLimit : n;
                end else begin
                    tok_stop = 1;
                end
            end
            frame_bytes++;
            if (frame_bytes >= MAX_FRAME_BYTES - 1)
                close_frame();
        end
    endtask

    task automatic check_result;
        t_frame_out want;
        t_res got;
        int i;
        results++;
        if (calibrated_q.size() == 0) begin
            $display("%0t: unexpected result, frame_status %0b", $time, m_axis_tuser);
            errors++;
        end else begin
            want = calibrated_q.pop_front();
            if (m_axis_tuser !== want.status) begin
                $display("%0t: frame_status expected %0b, got %0b",
                         $time, want.status, m_axis_tuser);
                errors++;
            end
            for (i = 0; i < NumChan; i++) begin
                got = m_axis_tdata[i * OutW +: OutW];
                if (got !== want.res[i]) begin
                    $display("%0t: %s expected %0d, got %0d", $time, chan_name(i),
                             $signed(want.res[i]), $signed(got));
                    errors++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_frame = 0;
            clear_token_state();
            chan_val = '0;
            bias[0] = '0;
            bias[1] = '0;
            bias[2] = '0;
            gain[0] = {NumLane{ScaleOne}};
            gain[1] = {NumLane{ScaleOne}};
            gain[2] = {NumLane{ScaleOne}};
            calibrated_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CfgMagBias:    bias[0] = i_cfg_data;
                    CfgAccelBias:  bias[1] = i_cfg_data;
                    CfgGyroBias:   bias[2] = i_cfg_data;
                    CfgMagScale:   gain[0] = i_cfg_data;
                    CfgAccelScale: gain[1] = i_cfg_data;
                    CfgGyroScale:  gain[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata);
        end
        o_errors  = errors;
        o_pending = calibrated_q.size();
        o_results = results;
    end

endmodule

/* tb/testbench.sv */
// Testbench top for the IMU text frame calibrator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
    import itfc_pkg::*;

    localparam int IdleLimit      = 4000;
    localparam int HoldCycles     = 600;
    localparam int DrainCycles    = 30;
    localparam int ItemsPerBlock  = 320;
    localparam int FramesPerBlock = 4;

    localparam logic [7:0] CharLf = 8'h0A;
    localparam logic [7:0] CharVt = 8'h0B;
    localparam logic [7:0] CharFf = 8'h0C;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata = '0;     // rx_byte
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    // mag_x, mag_y, mag_z, accel_x, accel_y, accel_z, rate_p, rate_q, rate_r
    logic [375:0]    m_axis_tdata;
    logic            m_axis_tuser;          // frame_status
    logic            i_cfg_we = 1'b0;
    logic [2:0]      i_cfg_idx = '0;
    logic [CfgW-1:0] i_cfg_data = '0;

    int chk_errors;
    int chk_pending;
    int chk_results;
    int snd_idle_pct = 14;
    int rcv_idle_pct = 77;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;
    int n_items = 0;
    int n_frames = 0;
    logic [7:0] tx_q[$];

    imu_text_frame_calibrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    frame_calib_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (chk_errors),
        .o_pending     (chk_pending),
        .o_results     (chk_results)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random back-pressure, plus a long hold on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IdleLimit) begin
            $display("watchdog: no item moved for %0d cycles", IdleLimit);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] random_sep;
        case ($urandom_range(9))
            0: return CharTab;
            1: return CharLf;
            2: return CharVt;
            3: return CharFf;
            4: return CharCr;
            5: return CharNul;
            default: return CharSpace;
        endcase
    endfunction

    // any byte that neither separates, ends a frame nor is a digit
    function automatic logic [7:0] junk_char;
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CharZ || c == CharSpace || (c >= CharTab && c <= CharCr) ||
               (c >= Char0 && c <= Char9));
        return c;
    endfunction

    function automatic logic [CfgW-1:0] bias_word(input int mode);
        case (mode)
            0: return {NumLane{20'h7FFFF}};
            1: return {NumLane{20'h80000}};
            default: return CfgW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [CfgW-1:0] gain_word(input int mode);
        case (mode)
            0: return {NumLane{20'h80000}};
            1: return {NumLane{20'h7FFFF}};
            default: return CfgW'({$urandom, $urandom});
        endcase
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            tx_q.push_back(s[i]);
    endtask

    task automatic add_sep;
        repeat ($urandom_range(1, 3))
            tx_q.push_back(random_sep());
    endtask

    task automatic add_token;
        int kind;
        int nd;
        kind = $urandom_range(99);
        if (kind < 8) begin
            tx_q.push_back($urandom_range(1) ? CharMinus : CharPlus);
        end else if (kind < 12) begin
            tx_q.push_back(junk_char());
            tx_q.push_back(8'(Char0 + $urandom_range(9)));
        end else begin
            if ($urandom_range(2) == 0)
                tx_q.push_back($urandom_range(1) ? CharMinus : CharPlus);
            nd = (kind < 22) ? $urandom_range(6, 9) : $urandom_range(1, 4);
            repeat (nd)
                tx_q.push_back(8'(Char0 + $urandom_range(9)));
            if (kind >= 22 && kind < 32) begin
                tx_q.push_back(junk_char());
                if ($urandom_range(1))
                    tx_q.push_back(8'(Char0 + $urandom_range(9)));
            end
        end
    endtask

    task automatic add_frame;
        int sel;
        int ntok;
        int k;
        int start;
        bit truncate;
        sel = $urandom_range(99);
        if (sel < 78)
            ntok = TokensWanted;
        else if (sel < 86)
            ntok = $urandom_range(0, TokensWanted - 1);
        else if (sel < 94)
            ntok = $urandom_range(TokensWanted + 1, 14);
        else
            ntok = $urandom_range(15, 19);
        truncate = ($urandom_range(99) < 4);
        tx_q.push_back(CharA);
        start = tx_q.size();
        if ($urandom_range(1))
            add_sep();
        for (k = 0; k < ntok; k++) begin
            add_token();
            if (k < ntok - 1 || $urandom_range(1))
                add_sep();
        end
        if (truncate) begin
            while (tx_q.size() - start < MAX_FRAME_BYTES - 1)
                tx_q.push_back(random_sep());
        end else begin
            tx_q.push_back(CharZ);
        end
        n_frames++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_queue;
        while (tx_q.size() != 0)
            push_byte(tx_q.pop_front());
    endtask

    task automatic wait_idle;
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CfgW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int mode);
        cfg_write(CfgMagBias, bias_word(mode));
        cfg_write(CfgAccelBias, bias_word(mode));
        cfg_write(CfgGyroBias, bias_word(mode));
        cfg_write(CfgMagScale, gain_word(mode));
        cfg_write(CfgAccelScale, gain_word(mode));
        cfg_write(CfgGyroScale, gain_word(mode));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int blk;
        int blk_items;
        int blk_frames;
        int total_errors;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes outside a frame, an empty frame, then one frame with every token corner
        tx_q.push_back(8'hFF);
        tx_q.push_back(CharZ);
        add_text("AZ");
        add_text("A0");
        tx_q.push_back(CharTab);
        add_text("-600000");
        tx_q.push_back(CharLf);
        add_text("600000");
        tx_q.push_back(CharVt);
        add_text("-");
        tx_q.push_back(CharFf);
        add_text("x");
        tx_q.push_back(CharCr);
        add_text("1q");
        tx_q.push_back(CharNul);
        add_text("+5 A 7 8Z");
        n_frames += 2;
        send_queue();

        for (blk = 0; blk < 4; blk++) begin
            wait_idle();
            program_regs(blk);
            snd_idle_pct = (blk == 0) ? 14 : (blk == 1) ? 77 : 0;
            rcv_idle_pct = (blk == 0) ? 77 : (blk == 1) ? 14 : 0;
            if (blk == 2)
                hold_reqs++;
            blk_items  = n_items;
            blk_frames = n_frames;
            while (n_items - blk_items < ItemsPerBlock ||
                   n_frames - blk_frames < FramesPerBlock) begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 4))
                        tx_q.push_back(8'($urandom_range(255)));
                add_frame();
                send_queue();
            end
        end
        wait_idle();

        total_errors = chk_errors + chk_pending;
        $display("Sent %0d serial bytes in %0d frames, %0d frame results checked,",
                 n_items, n_frames, chk_results);
        $display("across default, extreme and random calibration and three flow patterns.");
        if (total_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/itfc_pkg.sv
rtl/itfc_front.sv
rtl/itfc_queue.sv
rtl/itfc_back.sv
rtl/imu_text_frame_calibrator.sv
tb/frame_calib_checker.sv
tb/testbench.sv
